FILE: src/pixel_run_length_encoder_assert.svh
// Assertion macros shared by the checkers of the pixel run-length encoder.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef PIXEL_RUN_LENGTH_ENCODER_ASSERT_SVH
`define PIXEL_RUN_LENGTH_ENCODER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define PRLE_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("pixel run-length encoder assertion failed");

// A condition that, when true, requires a consequence in the next cycle.
`define PRLE_ASSERT_NEXT(label, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error("pixel run-length encoder assertion failed");

`endif

FILE: src/prle_pkg.sv
// Shared types and constants of the pixel run-length encoder.
// Used by the front, command queue, back, top level and checker; no dependencies.
`default_nettype none

package prle_pkg;

	localparam int MAX_CHANNELS = 4;
	localparam int RUN_LIMIT    = 255;
	localparam int NUM_LANES    = 4;
	localparam int CH_W         = 3;
	localparam int BUDGET_W     = 24;
	localparam int SUM_W        = BUDGET_W + 2;
	localparam int CMDQ_DEPTH   = 4;
	localparam int CMDQ_AW      = $clog2(CMDQ_DEPTH);

	typedef enum logic [0:0] {
		REG_CHANNEL_COUNT = 1'b0,
		REG_OUTPUT_BUDGET = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] chan0;
		logic [7:0] chan1;
		logic [7:0] chan2;
		logic [7:0] chan3;
		logic       last_pixel;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_error;
		logic       out_last;
	} res_out_t;

	typedef struct packed {
		logic                  err;
		logic                  tail;
		logic [7:0]            count;
		logic [8*NUM_LANES-1:0] pix;
		logic [CH_W-1:0]       nch;
	} cmd_t;

	typedef struct packed {
		logic [1:0] cnt;
		cmd_t       cmd0;
		cmd_t       cmd1;
	} cmd_wr_t;

endpackage

`default_nettype wire

FILE: src/pixel_run_length_encoder.sv
// Top level of the pixel run-length encoder.
// Instantiates prle_front, prle_cmd_queue and prle_back; depends on prle_pkg.
//
// Usage:
// Pixels enter through a queue-style port: an item is taken at a clock edge with push
// high and full low. Results leave the same way: while empty is low the oldest result
// sits on result, and it is taken at an edge with pop high.
// Configuration is written through cfg_valid, cfg_index and cfg_data; cfg_ready is
// always high. Register 0 is the channel count, register 1 the output budget.
// A pixel that closes a run has its command written into the command queue, and the
// back then loads the first result byte into the output register. A run goes out as
// channel_count plus one bytes, one byte per cycle while the receiver pops, so with
// every pixel different the throughput is set by the single output byte lane. Pixels
// that extend a run go in one per cycle while full is low. Reset clears the open run,
// the byte total and the error state, and loads defaults of three channels and a full budget.
// When the receiver stops popping, the output register holds its result, the back
// stops, the four-entry command queue fills and full rises once fewer than two of its
// entries are free, until results drain.
`default_nettype none

module pixel_run_length_encoder import prle_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire pix_in_t             pixel,
	output logic                     empty,
	input  wire logic                pop,
	output res_out_t                 result,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire cfg_reg_t            cfg_index,
	input  wire logic [BUDGET_W-1:0] cfg_data
);

	logic    room2;
	logic    accept;
	cmd_wr_t wr;
	logic    head_valid;
	cmd_t    head;
	logic    head_pop;
	logic    out_valid;

	assign full   = !room2;
	assign accept = push && room2;
	assign empty  = !out_valid;

	prle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.pixel     (pixel),
		.wr        (wr)
	);

	prle_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.room2      (room2),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop)
	);

	prle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (head_valid),
		.cmd       (head),
		.cmd_pop   (head_pop),
		.out_valid (out_valid),
		.out_data  (result),
		.out_take  (pop && out_valid)
	);

endmodule

`default_nettype wire

FILE: src/prle_front.sv
// Front of the pixel run-length encoder: configuration registers, run tracking and budget check.
// Turns accepted pixels into run commands for the command queue; depends on prle_pkg.
`default_nettype none

module prle_front import prle_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire cfg_reg_t        cfg_index,
	input  wire logic [BUDGET_W-1:0] cfg_data,
	input  wire logic            accept,
	input  wire pix_in_t         pixel,
	output cmd_wr_t              wr
);

	logic [CH_W-1:0]          cc_q;
	logic [BUDGET_W-1:0]      budget_q;
	logic [8*NUM_LANES-1:0]   run_pixel_q;
	logic [7:0]               run_len_q;
	logic [BUDGET_W-1:0]      bytes_q;
	logic                     failed_q;

	logic [CH_W-1:0]          ch;
	logic [8*NUM_LANES-1:0]   pix;
	logic [NUM_LANES-1:0]     lane_diff;
	logic                     diff;
	logic [SUM_W-1:0]         inc1;
	logic [SUM_W-1:0]         sum1;
	logic [SUM_W-1:0]         sum2;
	logic                     over1;
	logic                     over2;
	logic                     over_next;
	logic [SUM_W-1:0]         be_next;
	logic                     fresh;
	logic [7:0]               new_len;
	logic [8*NUM_LANES-1:0]   new_pix;
	cmd_t                     run_cmd;
	cmd_t                     err_cmd;
	cmd_t                     new_cmd;

	logic [8*NUM_LANES-1:0]   run_pixel_d;
	logic [7:0]               run_len_d;
	logic [BUDGET_W-1:0]      bytes_d;
	logic                     failed_d;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (cc_q == '0) begin
			ch = CH_W'(1);
		end else if (cc_q > CH_W'(MAX_CHANNELS)) begin
			ch = CH_W'(MAX_CHANNELS);
		end else begin
			ch = cc_q;
		end
	end

	assign pix = {pixel.chan3, pixel.chan2, pixel.chan1, pixel.chan0};

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			lane_diff[i] = (i < int'(ch)) && (run_pixel_q[8*i +: 8] != pix[8*i +: 8]);
		end
	end

	assign diff    = (run_len_q != 8'd0) && (lane_diff != '0);
	assign inc1    = SUM_W'(ch) + SUM_W'(1);
	assign sum1    = SUM_W'(bytes_q) + inc1;
	assign sum2    = SUM_W'(bytes_q) + {inc1[SUM_W-2:0], 1'b0};
	assign over1   = sum1 > SUM_W'(budget_q);
	assign over2   = sum2 > SUM_W'(budget_q);
	assign over_next = diff ? over2 : over1;
	assign be_next   = diff ? sum2 : sum1;
	assign fresh     = diff || (run_len_q == 8'd0);
	assign new_len   = fresh ? 8'd1 : run_len_q + 8'd1;
	assign new_pix   = fresh ? pix : run_pixel_q;

	always_comb begin
		run_cmd.err   = 1'b0;
		run_cmd.tail  = 1'b0;
		run_cmd.count = run_len_q;
		run_cmd.pix   = run_pixel_q;
		run_cmd.nch   = ch;

		err_cmd.err   = 1'b1;
		err_cmd.tail  = 1'b1;
		err_cmd.count = 8'd0;
		err_cmd.pix   = '0;
		err_cmd.nch   = ch;

		if (over_next) begin
			new_cmd = err_cmd;
		end else begin
			new_cmd.err   = 1'b0;
			new_cmd.tail  = pixel.last_pixel;
			new_cmd.count = new_len;
			new_cmd.pix   = new_pix;
			new_cmd.nch   = ch;
		end
	end

	always_comb begin
		run_pixel_d = run_pixel_q;
		run_len_d   = run_len_q;
		bytes_d     = bytes_q;
		failed_d    = failed_q;
		wr.cnt      = 2'd0;
		wr.cmd0     = run_cmd;
		wr.cmd1     = new_cmd;
		if (accept) begin
			if (failed_q) begin
				if (pixel.last_pixel) begin
					run_pixel_d = '0;
					run_len_d   = 8'd0;
					bytes_d     = '0;
					failed_d    = 1'b0;
				end
			end else if (diff && over1) begin
				wr.cnt  = 2'd1;
				wr.cmd0 = err_cmd;
				run_len_d = 8'd0;
				if (pixel.last_pixel) begin
					run_pixel_d = '0;
					bytes_d     = '0;
				end else begin
					failed_d = 1'b1;
				end
			end else if (pixel.last_pixel) begin
				if (diff) begin
					wr.cnt = 2'd2;
				end else begin
					wr.cnt  = 2'd1;
					wr.cmd0 = new_cmd;
				end
				run_pixel_d = '0;
				run_len_d   = 8'd0;
				bytes_d     = '0;
				failed_d    = 1'b0;
			end else if (new_len >= 8'(RUN_LIMIT)) begin
				wr.cnt      = 2'd1;
				wr.cmd0     = new_cmd;
				run_pixel_d = new_pix;
				run_len_d   = 8'd0;
				if (over_next) begin
					failed_d = 1'b1;
				end else begin
					bytes_d = be_next[BUDGET_W-1:0];
				end
			end else begin
				if (diff) begin
					wr.cnt  = 2'd1;
					bytes_d = sum1[BUDGET_W-1:0];
				end
				run_pixel_d = new_pix;
				run_len_d   = new_len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q        <= CH_W'(3);
			budget_q    <= '1;
			run_pixel_q <= '0;
			run_len_q   <= 8'd0;
			bytes_q     <= '0;
			failed_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_CHANNEL_COUNT: cc_q     <= cfg_data[CH_W-1:0];
					REG_OUTPUT_BUDGET: budget_q <= cfg_data;
					default: ;
				endcase
			end
			run_pixel_q <= run_pixel_d;
			run_len_q   <= run_len_d;
			bytes_q     <= bytes_d;
			failed_q    <= failed_d;
		end
	end

endmodule

`default_nettype wire

FILE: src/prle_cmd_queue.sv
// Short command queue between the front and the back of the pixel run-length encoder.
// Takes up to two run commands per cycle and hands out one; depends on prle_pkg.
`default_nettype none

module prle_cmd_queue import prle_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cmd_wr_t wr,
	output logic         room2,
	output logic         head_valid,
	output cmd_t         head,
	input  wire logic    head_pop
);

	cmd_t               entries_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] head_q;
	logic [CMDQ_AW-1:0] tail_q;
	logic [CMDQ_AW:0]   count_q;
	logic [CMDQ_AW-1:0] tail_next;

	assign tail_next  = tail_q + CMDQ_AW'(1);
	assign room2      = count_q <= (CMDQ_AW+1)'(CMDQ_DEPTH - 2);
	assign head_valid = count_q != '0;
	assign head       = entries_q[head_q];

	always_ff @(posedge clk) begin
		if (wr.cnt != 2'd0) begin
			entries_q[tail_q] <= wr.cmd0;
		end
		if (wr.cnt == 2'd2) begin
			entries_q[tail_next] <= wr.cmd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + CMDQ_AW'(wr.cnt);
			head_q  <= head_q + CMDQ_AW'(head_pop);
			count_q <= count_q + (CMDQ_AW+1)'(wr.cnt) - (CMDQ_AW+1)'(head_pop);
		end
	end

endmodule

`default_nettype wire

FILE: src/prle_back.sv
// Back of the pixel run-length encoder: serializes run commands into result bytes.
// Holds the output register seen on the result ports; depends on prle_pkg.
`default_nettype none

module prle_back import prle_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      cmd_pop,
	output logic      out_valid,
	output res_out_t  out_data,
	input  wire logic out_take
);

	logic [CH_W-1:0] idx_q;
	logic            out_valid_q;
	res_out_t        out_q;
	logic            load;
	logic            done;
	res_out_t        next_res;

	assign load    = cmd_valid && (!out_valid_q || out_take);
	assign done    = cmd.err || (idx_q == cmd.nch);
	assign cmd_pop = load && done;

	always_comb begin
		next_res.is_error = cmd.err;
		next_res.out_last = cmd.err || (cmd.tail && (idx_q == cmd.nch));
		if (cmd.err) begin
			next_res.out_byte = 8'd0;
		end else if (idx_q == '0) begin
			next_res.out_byte = cmd.count;
		end else begin
			next_res.out_byte = cmd.pix[{idx_q[1:0] - 2'd1, 3'b000} +: 8];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= next_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= done ? '0 : idx_q + CH_W'(1);
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

FILE: src/prle_checker.sv
// Port-level checker of the pixel run-length encoder, bound to the top level.
// Depends on prle_pkg and the macros in pixel_run_length_encoder_assert.svh.
`default_nettype none

`include "pixel_run_length_encoder_assert.svh"

module prle_checker import prle_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     empty,
	input wire logic     pop,
	input wire res_out_t result,
	input wire logic     cfg_valid,
	input wire logic     cfg_ready
);

	// A waiting result that is not popped stays on the ports unchanged.
	`PRLE_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(result))
	// The error result always closes the image.
	`PRLE_ASSERT(a_error_is_last, empty || !result.is_error || result.out_last)
	// The error result carries a zero byte.
	`PRLE_ASSERT(a_error_zero_byte, empty || !result.is_error || (result.out_byte == 8'd0))
	// Configuration writes are never held off.
	`PRLE_ASSERT(a_cfg_always_ready, !cfg_valid || cfg_ready)

endmodule

bind pixel_run_length_encoder prle_checker u_prle_checker (.*);

`default_nettype wire
